>>> design/itp_pkg.sv
// Shared types and constants of the integer text parser.
`timescale 1ns / 1ps

package itp_pkg;

   localparam int unsigned CHAR_W   = 8;
   localparam int unsigned VALUE_W  = 64;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned INDEX_W  = 2;
   localparam int unsigned DATA_W   = 7;
   localparam int unsigned RADIX_W  = 6;
   localparam int unsigned BITS_W   = 7;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_SYNTAX  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_SETTING = 2'd3;

   localparam logic [INDEX_W-1:0] REG_RADIX       = 2'd0;
   localparam logic [INDEX_W-1:0] REG_RESULT_BITS = 2'd1;
   localparam logic [INDEX_W-1:0] REG_SIGNED_MODE = 2'd2;

   localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
   localparam logic [BITS_W-1:0]  BITS_MAX    = 7'd64;

   typedef struct packed {
      logic [CHAR_W-1:0] text_byte;
      logic              has_byte;
      logic              end_of_string;
   } item_type;

endpackage

>>> design/itp_channels.sv
// Handshake channel interfaces of the integer text parser.
`timescale 1ns / 1ps

interface itp_req_if;
   logic                        valid;
   logic                        ready;
   logic [itp_pkg::CHAR_W-1:0]  text_byte;
   logic                        has_byte;
   logic                        end_of_string;

   modport source (output valid, output text_byte, output has_byte,
                   output end_of_string, input ready);
   modport sink (input valid, input text_byte, input has_byte,
                 input end_of_string, output ready);
endinterface

interface itp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [itp_pkg::VALUE_W-1:0]   value;
   logic [itp_pkg::STATUS_W-1:0]  status;

   modport source (output valid, output value, output status, input ready);
   modport sink (input valid, input value, input status, output ready);
endinterface

interface itp_csr_if;
   logic                         valid;
   logic                         ready;
   logic [itp_pkg::INDEX_W-1:0]  index;
   logic [itp_pkg::DATA_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

>>> design/integer_text_parser.sv
// Top level of the integer text parser: character stream in, value and status out.
`timescale 1ns / 1ps

// Channel  Direction  Word                                      Accepted when
// req_bus  in         text_byte, has_byte, end_of_string        valid && ready
// rsp_bus  out        value, status                             valid && ready
// csr_bus  in         index, data                               valid && ready
//
// Each word is captured in an input register and consumed from it, so one word is taken per
// cycle while the input is not stalled. The result of a string is registered when its
// last word is consumed from the input register, and is held until rsp_bus takes it.
// A result waiting on rsp_bus stalls the input only while the word in the input register
// ends a string.
// Reset is synchronous; it restores the configuration defaults and clears the handshake and parse registers.

module integer_text_parser #(
   parameter int unsigned NATIVE_INT_BITS = 64
) (
   input logic      clock,
   input logic      reset,
   itp_req_if.sink  req_bus,
   itp_rsp_if.source rsp_bus,
   itp_csr_if.sink  csr_bus
);

   localparam logic [2:0] PH_START  = 3'd0;
   localparam logic [2:0] PH_SIGN   = 3'd1;
   localparam logic [2:0] PH_ZERO   = 3'd2;
   localparam logic [2:0] PH_PREFIX = 3'd3;
   localparam logic [2:0] PH_FIXED  = 3'd4;
   localparam logic [2:0] PH_AUTO   = 3'd5;

   localparam logic [1:0] CL_BEGIN = 2'd0;
   localparam logic [1:0] CL_DIGIT = 2'd1;
   localparam logic [1:0] CL_UNDER = 2'd2;

   localparam int unsigned VW = itp_pkg::VALUE_W;

   logic [itp_pkg::RADIX_W-1:0]  radix_ff;
   logic [itp_pkg::BITS_W-1:0]   bits_ff;
   logic                         signed_ff;

   logic                         in_valid_ff;
   itp_pkg::item_type            in_ff;

   logic [VW-1:0]                acc_ff,   acc_in;
   logic                         neg_ff,   neg_in;
   logic [itp_pkg::STATUS_W-1:0] err_ff,   err_in;
   logic [2:0]                   phase_ff, phase_in;
   logic [itp_pkg::RADIX_W-1:0]  base_ff,  base_in;
   logic [1:0]                   sepc_ff,  sepc_in;
   logic                         seps_ff,  seps_in;
   logic                         sepb_ff,  sepb_in;

   logic                         out_valid_ff;
   logic [VW-1:0]                value_ff, value_in;
   logic [itp_pkg::STATUS_W-1:0] status_ff, status_in;

   logic                         advance;
   logic                         out_free;

   logic [itp_pkg::CHAR_W-1:0]   chr;
   logic [itp_pkg::CHAR_W-1:0]   lc;
   logic                         dig_ok;
   logic [itp_pkg::RADIX_W-1:0]  dig_val;
   logic [itp_pkg::BITS_W-1:0]   eff_bits;
   logic [VW-1:0]                range_max;
   logic [VW-1:0]                cut;
   logic                         start;
   logic                         do_digit;
   logic [VW+6:0]                total;
   logic [VW-1:0]                un;
   logic                         setting_bad;
   logic [itp_pkg::STATUS_W-1:0] fin_err;

   // Configuration registers.
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff  <= itp_pkg::RADIX_RESET;
         bits_ff   <= '0;
         signed_ff <= 1'b1;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            itp_pkg::REG_RADIX:       radix_ff  <= csr_bus.data[itp_pkg::RADIX_W-1:0];
            itp_pkg::REG_RESULT_BITS: bits_ff   <= csr_bus.data;
            itp_pkg::REG_SIGNED_MODE: signed_ff <= csr_bus.data[0];
            default: ;
         endcase
      end
   end

   // Input register and result register handshake.
   assign out_free      = !out_valid_ff || rsp_bus.ready;
   assign advance       = in_valid_ff && (!in_ff.end_of_string || out_free);
   assign req_bus.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         in_ff.text_byte     <= req_bus.text_byte;
         in_ff.has_byte      <= req_bus.has_byte;
         in_ff.end_of_string <= req_bus.end_of_string;
      end
   end

   // Character decode and range limits.
   always_comb begin
      chr     = in_ff.text_byte;
      lc      = chr | 8'h20;
      dig_ok  = 1'b0;
      dig_val = '0;
      if (chr >= "0" && chr <= "9") begin
         dig_ok  = 1'b1;
         dig_val = itp_pkg::RADIX_W'(chr - "0");
      end else if (lc >= "a" && lc <= "z") begin
         dig_ok  = 1'b1;
         dig_val = itp_pkg::RADIX_W'(lc - "a" + 8'd10);
      end
      if (bits_ff == '0) begin
         eff_bits = itp_pkg::BITS_W'(NATIVE_INT_BITS);
      end else if (bits_ff > itp_pkg::BITS_MAX) begin
         eff_bits = itp_pkg::BITS_MAX;
      end else begin
         eff_bits = bits_ff;
      end
      range_max   = {VW{1'b1}} >> (itp_pkg::BITS_MAX - eff_bits);
      cut         = {{(VW-1){1'b0}}, 1'b1} << (eff_bits - 7'd1);
      setting_bad = (radix_ff == 6'd1) || (radix_ff > itp_pkg::RADIX_MAX)
                    || (bits_ff > itp_pkg::BITS_MAX);
   end

   // Per-character state update.
   always_comb begin
      acc_in   = acc_ff;
      neg_in   = neg_ff;
      err_in   = err_ff;
      phase_in = phase_ff;
      base_in  = base_ff;
      sepc_in  = sepc_ff;
      seps_in  = seps_ff;
      sepb_in  = sepb_ff;
      start    = 1'b0;
      do_digit = 1'b0;
      total    = '0;

      if (in_ff.has_byte && err_ff == itp_pkg::ST_OK) begin
         case (phase_ff)
            PH_START: begin
               if (signed_ff && (chr == "+" || chr == "-")) begin
                  neg_in   = (chr == "-");
                  phase_in = PH_SIGN;
               end else begin
                  start = 1'b1;
               end
            end
            PH_SIGN: begin
               start = 1'b1;
            end
            PH_ZERO: begin
               if (lc == "b" || lc == "o" || lc == "x") begin
                  base_in  = (lc == "b") ? 6'd2 : (lc == "o") ? 6'd8 : 6'd16;
                  phase_in = PH_PREFIX;
               end else begin
                  base_in  = 6'd8;
                  phase_in = PH_AUTO;
                  do_digit = 1'b1;
               end
            end
            PH_PREFIX: begin
               phase_in = PH_AUTO;
               do_digit = 1'b1;
            end
            default: begin
               do_digit = 1'b1;
            end
         endcase

         if (start) begin
            if (setting_bad) begin
               err_in   = itp_pkg::ST_SETTING;
               phase_in = PH_FIXED;
            end else if (radix_ff == '0) begin
               if (chr == "0") begin
                  phase_in = PH_ZERO;
                  sepc_in  = CL_DIGIT;
               end else begin
                  base_in  = 6'd10;
                  phase_in = PH_AUTO;
                  do_digit = 1'b1;
               end
            end else begin
               base_in  = radix_ff;
               phase_in = PH_FIXED;
               do_digit = 1'b1;
            end
         end

         if (do_digit) begin
            if (chr == "_" && phase_in == PH_AUTO) begin
               seps_in = 1'b1;
               if (sepc_ff != CL_DIGIT) begin
                  sepb_in = 1'b1;
               end
               sepc_in = CL_UNDER;
            end else if (!dig_ok || base_in < 6'd2 || dig_val >= base_in) begin
               err_in = itp_pkg::ST_SYNTAX;
            end else begin
               sepc_in = CL_DIGIT;
               total   = {7'd0, acc_ff} * {65'd0, base_in} + {65'd0, dig_val};
               if (total > {7'd0, range_max}) begin
                  err_in = itp_pkg::ST_RANGE;
                  acc_in = range_max;
               end else begin
                  acc_in = total[VW-1:0];
               end
            end
         end
      end
   end

   // Final value and status of a string.
   always_comb begin
      fin_err = err_in;
      if (fin_err == itp_pkg::ST_OK) begin
         if (phase_in == PH_START || phase_in == PH_SIGN || phase_in == PH_PREFIX) begin
            fin_err = itp_pkg::ST_SYNTAX;
         end else if (phase_in == PH_AUTO && seps_in && (sepb_in || sepc_in == CL_UNDER)) begin
            fin_err = itp_pkg::ST_SYNTAX;
         end
      end
      status_in = fin_err;
      if (fin_err == itp_pkg::ST_SYNTAX || fin_err == itp_pkg::ST_SETTING) begin
         un = '0;
      end else begin
         un = acc_in;
      end
      if (signed_ff) begin
         if (!neg_in && un >= cut) begin
            if (status_in == itp_pkg::ST_OK) begin
               status_in = itp_pkg::ST_RANGE;
            end
            value_in = cut - 64'd1;
         end else if (neg_in && un > cut) begin
            if (status_in == itp_pkg::ST_OK) begin
               status_in = itp_pkg::ST_RANGE;
            end
            value_in = '0 - cut;
         end else begin
            value_in = neg_in ? ('0 - un) : un;
         end
      end else begin
         value_in = un;
      end
   end

   // Parse state registers; cleared when a string closes.
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         neg_ff   <= 1'b0;
         err_ff   <= itp_pkg::ST_OK;
         phase_ff <= PH_START;
         base_ff  <= '0;
         sepc_ff  <= CL_BEGIN;
         seps_ff  <= 1'b0;
         sepb_ff  <= 1'b0;
      end else if (advance) begin
         if (in_ff.end_of_string) begin
            acc_ff   <= '0;
            neg_ff   <= 1'b0;
            err_ff   <= itp_pkg::ST_OK;
            phase_ff <= PH_START;
            base_ff  <= '0;
            sepc_ff  <= CL_BEGIN;
            seps_ff  <= 1'b0;
            sepb_ff  <= 1'b0;
         end else begin
            acc_ff   <= acc_in;
            neg_ff   <= neg_in;
            err_ff   <= err_in;
            phase_ff <= phase_in;
            base_ff  <= base_in;
            sepc_ff  <= sepc_in;
            seps_ff  <= seps_in;
            sepb_ff  <= sepb_in;
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && in_ff.end_of_string) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_ff.end_of_string) begin
         value_ff  <= value_in;
         status_ff <= status_in;
      end
   end

   assign rsp_bus.valid  = out_valid_ff;
   assign rsp_bus.value  = value_ff;
   assign rsp_bus.status = status_ff;

   // Checks.
   a_close_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance && in_ff.end_of_string |=> rsp_bus.valid)
      else $error("closing word did not produce a result");

   a_close_clears_state: assert property (@(posedge clock) disable iff (reset)
      advance && in_ff.end_of_string |=> phase_ff == PH_START && err_ff == itp_pkg::ST_OK)
      else $error("parse state not cleared after a string");

   a_error_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && (rsp_bus.status == itp_pkg::ST_SYNTAX
                        || rsp_bus.status == itp_pkg::ST_SETTING) |-> rsp_bus.value == '0)
      else $error("syntax or setting error with nonzero value");

   a_digit_base_valid: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_AUTO |-> base_ff >= 6'd2)
      else $error("digit phase without a usable base");

endmodule

>>> dv/tb_top.sv
// Self-checking testbench of the integer text parser: random and directed number texts.
`timescale 1ns / 1ps

module tb_top;

   localparam int unsigned NATIVE_BITS = 64;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned RANDOM_PHASES = 12;
   localparam int unsigned WORDS_PER_PHASE = 56;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam logic [itp_pkg::INDEX_W-1:0] REG_UNUSED = 2'd3;
   localparam logic [itp_pkg::RADIX_W-1:0] RADIX_AUTO = 6'd0;
   localparam logic [63:0] ALL_ONES = '1;

   typedef enum logic [2:0] {
      SCAN_START, SCAN_SIGN, SCAN_ZERO, SCAN_PREFIX, SCAN_FIXED, SCAN_AUTO
   } scan_type;

   typedef enum logic [1:0] {SEP_BEGIN, SEP_DIGIT, SEP_UNDER} sep_type;

   typedef struct packed {
      logic [itp_pkg::VALUE_W-1:0]  value;
      logic [itp_pkg::STATUS_W-1:0] status;
   } number_type;

   typedef logic [7:0] char_q_type [$];

   logic clock = 1'b0;
   logic reset;

   itp_req_if req_bus ();
   itp_rsp_if rsp_bus ();
   itp_csr_if csr_bus ();

   integer_text_parser #(.NATIVE_INT_BITS(NATIVE_BITS)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #5 clock = ~clock;

   itp_pkg::item_type text_words [$];
   number_type        expected_numbers [$];
   logic              req_took = 1'b0;
   int unsigned       sender_idle = 30;
   int unsigned       receiver_idle = 51;
   int unsigned       words_sent = 0;
   int unsigned       mismatch_count = 0;
   int unsigned       cycle_count = 0;

   logic [itp_pkg::RADIX_W-1:0] cfg_radix = itp_pkg::RADIX_RESET;
   logic [itp_pkg::BITS_W-1:0]  cfg_bits = '0;
   logic                        cfg_signed = 1'b1;

   logic [63:0]                  acc;
   logic                         neg_sign;
   logic [itp_pkg::STATUS_W-1:0] first_err;
   scan_type                     scan;
   logic [itp_pkg::RADIX_W-1:0]  work_base;
   sep_type                      sep_cls;
   logic                         sep_seen;
   logic                         sep_bad;

   function automatic void clear_text();
      acc = '0;
      neg_sign = 1'b0;
      first_err = itp_pkg::ST_OK;
      scan = SCAN_START;
      work_base = '0;
      sep_cls = SEP_BEGIN;
      sep_seen = 1'b0;
      sep_bad = 1'b0;
   endfunction

   function automatic int unsigned eff_bits();
      int unsigned b;
      b = cfg_bits;
      if (b == 0) b = NATIVE_BITS;
      if (b > 64) b = 64;
      return b;
   endfunction

   function automatic logic [63:0] range_top();
      return ALL_ONES >> (64 - eff_bits());
   endfunction

   function automatic void scan_digit(logic [7:0] c);
      logic [7:0]  lc;
      int unsigned d;
      logic [63:0] base;
      logic [63:0] sum;
      lc = c | 8'h20;
      base = 64'(work_base);
      if (c == "_" && scan == SCAN_AUTO) begin
         sep_seen = 1'b1;
         if (sep_cls != SEP_DIGIT) sep_bad = 1'b1;
         sep_cls = SEP_UNDER;
         return;
      end
      if (c >= "0" && c <= "9") begin
         d = c - "0";
      end else if (lc >= "a" && lc <= "z") begin
         d = lc - "a" + 10;
      end else begin
         first_err = itp_pkg::ST_SYNTAX;
         return;
      end
      if (base < 2 || 64'(d) >= base) begin
         first_err = itp_pkg::ST_SYNTAX;
         return;
      end
      sep_cls = SEP_DIGIT;
      if (acc >= ALL_ONES / base + 64'd1) begin
         first_err = itp_pkg::ST_RANGE;
         acc = range_top();
         return;
      end
      acc = acc * base;
      sum = acc + 64'(d);
      if (sum < acc || sum > range_top()) begin
         first_err = itp_pkg::ST_RANGE;
         acc = range_top();
         return;
      end
      acc = sum;
   endfunction

   function automatic void start_number(logic [7:0] c);
      if (cfg_radix == 6'd1 || cfg_radix > itp_pkg::RADIX_MAX
          || cfg_bits > itp_pkg::BITS_MAX) begin
         first_err = itp_pkg::ST_SETTING;
         scan = SCAN_FIXED;
      end else if (cfg_radix == RADIX_AUTO) begin
         if (c == "0") begin
            scan = SCAN_ZERO;
            sep_cls = SEP_DIGIT;
         end else begin
            work_base = 6'd10;
            scan = SCAN_AUTO;
            scan_digit(c);
         end
      end else begin
         work_base = cfg_radix;
         scan = SCAN_FIXED;
         scan_digit(c);
      end
   endfunction

   function automatic void take_char(logic [7:0] c);
      logic [7:0] lc;
      lc = c | 8'h20;
      case (scan)
         SCAN_START: begin
            if (cfg_signed && (c == "+" || c == "-")) begin
               neg_sign = (c == "-");
               scan = SCAN_SIGN;
            end else begin
               start_number(c);
            end
         end
         SCAN_SIGN: start_number(c);
         SCAN_ZERO: begin
            if (lc == "b" || lc == "o" || lc == "x") begin
               work_base = (lc == "b") ? 6'd2 : (lc == "o") ? 6'd8 : 6'd16;
               scan = SCAN_PREFIX;
            end else begin
               work_base = 6'd8;
               scan = SCAN_AUTO;
               scan_digit(c);
            end
         end
         SCAN_PREFIX: begin
            scan = SCAN_AUTO;
            scan_digit(c);
         end
         default: scan_digit(c);
      endcase
   endfunction

   function automatic number_type close_text();
      number_type                   r;
      logic [63:0]                  un;
      logic [63:0]                  cut;
      logic [itp_pkg::STATUS_W-1:0] st;
      if (first_err == itp_pkg::ST_OK) begin
         if (scan == SCAN_START || scan == SCAN_SIGN || scan == SCAN_PREFIX) begin
            first_err = itp_pkg::ST_SYNTAX;
         end else if (scan == SCAN_AUTO && sep_seen && (sep_bad || sep_cls == SEP_UNDER)) begin
            first_err = itp_pkg::ST_SYNTAX;
         end
      end
      st = first_err;
      un = (st == itp_pkg::ST_SYNTAX || st == itp_pkg::ST_SETTING) ? 64'd0 : acc;
      r.value = un;
      if (cfg_signed) begin
         cut = 64'd1 << (eff_bits() - 1);
         if (!neg_sign && un >= cut) begin
            if (st == itp_pkg::ST_OK) st = itp_pkg::ST_RANGE;
            r.value = cut - 64'd1;
         end else if (neg_sign && un > cut) begin
            if (st == itp_pkg::ST_OK) st = itp_pkg::ST_RANGE;
            r.value = 64'd0 - cut;
         end else begin
            r.value = neg_sign ? 64'd0 - un : un;
         end
      end
      r.status = st;
      clear_text();
      return r;
   endfunction

   function automatic void parse_word(itp_pkg::item_type w);
      if (w.has_byte && first_err == itp_pkg::ST_OK) take_char(w.text_byte);
      if (w.end_of_string) expected_numbers.push_back(close_text());
   endfunction

   function automatic void apply_csr(logic [itp_pkg::INDEX_W-1:0] idx,
                                     logic [itp_pkg::DATA_W-1:0] val);
      case (idx)
         itp_pkg::REG_RADIX:       cfg_radix = val[itp_pkg::RADIX_W-1:0];
         itp_pkg::REG_RESULT_BITS: cfg_bits = val[itp_pkg::BITS_W-1:0];
         itp_pkg::REG_SIGNED_MODE: cfg_signed = val[0];
         default: ;
      endcase
   endfunction

   function automatic void note_failure(string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("mismatch: %s", msg);
   endfunction

   always @(posedge clock) begin : check_words
      number_type want;
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready) apply_csr(csr_bus.index, csr_bus.data);
         if (req_bus.valid && req_bus.ready) begin
            parse_word(itp_pkg::item_type'{text_byte: req_bus.text_byte,
                                           has_byte: req_bus.has_byte,
                                           end_of_string: req_bus.end_of_string});
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_numbers.size() == 0) begin
               note_failure($sformatf("unexpected result value %h status %0d",
                                      rsp_bus.value, rsp_bus.status));
            end else begin
               want = expected_numbers.pop_front();
               if (rsp_bus.value !== want.value || rsp_bus.status !== want.status) begin
                  note_failure($sformatf("value exp %h act %h, status exp %0d act %0d",
                                         want.value, rsp_bus.value, want.status,
                                         rsp_bus.status));
               end
            end
         end
      end
      req_took <= !reset && req_bus.valid && req_bus.ready;
   end

   always @(negedge clock) begin : drive_words
      itp_pkg::item_type w;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_took) begin
         if (text_words.size() != 0 && $urandom_range(0, 99) >= sender_idle) begin
            w = text_words.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.text_byte <= w.text_byte;
            req_bus.has_byte <= w.has_byte;
            req_bus.end_of_string <= w.end_of_string;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
      rsp_bus.ready <= ($urandom_range(0, 99) >= receiver_idle);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic drain();
      while (text_words.size() != 0 || req_bus.valid || expected_numbers.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(input logic [itp_pkg::INDEX_W-1:0] idx,
                            input logic [itp_pkg::DATA_W-1:0] val);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= val;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic set_config(input logic [itp_pkg::RADIX_W-1:0] rdx,
                             input logic [itp_pkg::BITS_W-1:0] bits,
                             input logic sgn);
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_reg(itp_pkg::REG_RADIX, {1'($urandom), rdx});
      write_reg(itp_pkg::REG_RESULT_BITS, bits);
      write_reg(itp_pkg::REG_SIGNED_MODE, {6'($urandom), sgn});
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, 7'($urandom));
   endtask

   task automatic push_text(input char_q_type chars, input bit bare_end, input bit noisy,
                            input bit split);
      itp_pkg::item_type w;
      for (int i = 0; i < chars.size(); i++) begin
         if (split && i == chars.size() / 2) drain();
         if (noisy && $urandom_range(0, 15) == 0) begin
            w.text_byte = 8'($urandom);
            w.has_byte = 1'b0;
            w.end_of_string = 1'b0;
            text_words.push_back(w);
         end
         w.text_byte = chars[i];
         w.has_byte = 1'b1;
         w.end_of_string = !bare_end && (i == chars.size() - 1);
         text_words.push_back(w);
         words_sent++;
      end
      if (bare_end || chars.size() == 0) begin
         w.text_byte = 8'($urandom);
         w.has_byte = 1'b0;
         w.end_of_string = 1'b1;
         text_words.push_back(w);
         words_sent++;
      end
   endtask

   function automatic char_q_type from_str(string s);
      char_q_type q;
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
      return q;
   endfunction

   function automatic logic [7:0] digit_char(int unsigned d);
      if (d < 10) return 8'("0" + d);
      return $urandom_range(0, 1) ? 8'("A" + d - 10) : 8'("a" + d - 10);
   endfunction

   function automatic logic [7:0] prefix_letter(int unsigned base, bit upper);
      logic [7:0] c;
      c = (base == 2) ? "b" : (base == 8) ? "o" : "x";
      return upper ? (c & 8'hDF) : c;
   endfunction

   function automatic char_q_type render(logic [63:0] v, int unsigned base);
      char_q_type  s;
      logic [63:0] b;
      b = 64'(base);
      if (v == 0) s.push_back("0");
      while (v != 0) begin
         s.push_front(digit_char(int'(v % b)));
         v = v / b;
      end
      return s;
   endfunction

   function automatic char_q_type make_text();
      char_q_type  s;
      char_q_type  digits;
      char_q_type  t;
      int unsigned kind;
      int unsigned base;
      int unsigned n;
      int unsigned pick;
      int unsigned eb;
      int unsigned dv;
      logic [63:0] v;
      logic [63:0] top;
      logic [63:0] cut;
      kind = $urandom_range(0, 99);
      eb = eff_bits();
      top = range_top();
      cut = 64'd1 << (eb - 1);
      pick = 0;
      if (kind < 10) begin
         if ($urandom_range(0, 1)) s.push_back($urandom_range(0, 1) ? "-" : "+");
         case ($urandom_range(0, 3))
            1: begin
               s.push_back("0");
               s.push_back(prefix_letter(2 << (2 * $urandom_range(0, 1)) + 2 *
                                         $urandom_range(0, 1), $urandom_range(0, 1)));
            end
            2: s.push_back("_");
            default: ;
         endcase
         return s;
      end
      if (kind < 25) begin
         n = $urandom_range(1, 6);
         repeat (n) s.push_back(8'($urandom_range(0, 255)));
         return s;
      end
      if (cfg_signed ? $urandom_range(0, 2) == 0 : $urandom_range(0, 19) == 0)
         s.push_back($urandom_range(0, 1) ? "-" : "+");
      if (cfg_radix == RADIX_AUTO) begin
         pick = $urandom_range(0, 4);
         base = (pick == 0) ? 10 : (pick == 1 || pick == 3) ? 8 : (pick == 2) ? 2 : 16;
         if (pick != 0) s.push_back("0");
         if (pick >= 2) s.push_back(prefix_letter(base, $urandom_range(0, 1)));
      end else if (cfg_radix >= 2 && cfg_radix <= itp_pkg::RADIX_MAX) begin
         base = cfg_radix;
      end else begin
         base = 10;
      end
      if (kind < 45) begin
         case ($urandom_range(0, 7))
            0: v = top;
            1: v = top - 64'd1;
            2: v = cut;
            3: v = cut - 64'd1;
            4: v = cut + 64'd1;
            5: v = 64'd0;
            default: v = (eb < 64) ? top + 64'd1 : top;
         endcase
         digits = render(v, base);
         if (eb == 64 && v == top && $urandom_range(0, 1))
            digits.push_back(digit_char($urandom_range(0, base - 1)));
      end else begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, (base <= 4) ? 70 : 26)
                                         : $urandom_range(0, 6);
         repeat (n) begin
            dv = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 35)
                                              : $urandom_range(0, base - 1);
            digits.push_back(digit_char(dv));
         end
      end
      if (cfg_radix == RADIX_AUTO && $urandom_range(0, 99) < 35) begin
         for (int i = 0; i < digits.size(); i++) begin
            if (i > 0 && $urandom_range(0, 2) == 0) t.push_back("_");
            t.push_back(digits[i]);
         end
         case ($urandom_range(0, 7))
            0: t.push_front("_");
            1: t.push_back("_");
            2: begin
               t.push_back("_");
               t.push_back("_");
               t.push_back(digit_char(0));
            end
            default: ;
         endcase
         digits = t;
      end
      foreach (digits[i]) s.push_back(digits[i]);
      return s;
   endfunction

   initial begin
      char_q_type                  txt;
      logic [itp_pkg::RADIX_W-1:0] rdx;
      logic [itp_pkg::BITS_W-1:0]  bits;
      logic                        sgn;
      int unsigned                 phase_start;
      bit                          split_done;

      reset = 1'b1;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
      clear_text();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      push_text(from_str(""), 1'b1, 1'b0, 1'b0);
      push_text(from_str("-"), 1'b0, 1'b0, 1'b0);
      push_text(from_str("12x3"), 1'b0, 1'b0, 1'b0);
      text_words.push_back(itp_pkg::item_type'{text_byte: 8'h39, has_byte: 1'b0,
                                               end_of_string: 1'b0});
      push_text(from_str("-9"), 1'b1, 1'b0, 1'b0);

      set_config(RADIX_AUTO, 7'd8, 1'b1);
      push_text(from_str("0x"), 1'b0, 1'b0, 1'b0);
      push_text(from_str("0"), 1'b0, 1'b0, 1'b0);
      push_text(from_str("0xff"), 1'b0, 1'b0, 1'b0);
      push_text(from_str("-0b1_0"), 1'b0, 1'b0, 1'b0);
      push_text(from_str("1__2"), 1'b0, 1'b0, 1'b0);
      push_text(from_str("_5"), 1'b1, 1'b0, 1'b0);
      push_text(from_str("0o7_"), 1'b0, 1'b0, 1'b0);

      set_config(6'd1, 7'd64, 1'b0);
      push_text(from_str("5"), 1'b0, 1'b0, 1'b0);
      push_text(from_str("-"), 1'b0, 1'b0, 1'b0);

      set_config(6'd63, 7'd127, 1'b1);
      push_text(from_str("+"), 1'b0, 1'b0, 1'b0);
      push_text(from_str("7"), 1'b0, 1'b0, 1'b0);

      set_config(itp_pkg::RADIX_MAX, 7'd64, 1'b0);
      push_text(from_str("zZ"), 1'b0, 1'b0, 1'b0);
      push_text(from_str("-1"), 1'b0, 1'b0, 1'b0);

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0: begin rdx = RADIX_AUTO; bits = 7'd64; sgn = 1'b1; end
            1: begin rdx = 6'd2;       bits = 7'd1;  sgn = 1'b0; end
            2: begin rdx = itp_pkg::RADIX_MAX; bits = 7'd64; sgn = 1'b1; end
            3: begin rdx = RADIX_AUTO; bits = 7'd8;  sgn = 1'b0; end
            4: begin rdx = 6'd16;      bits = 7'd32; sgn = 1'b1; end
            5: begin rdx = itp_pkg::RADIX_RESET; bits = 7'd0; sgn = 1'b0; end
            default: begin
               case ($urandom_range(0, 11))
                  0, 1, 2, 3: rdx = RADIX_AUTO;
                  4: rdx = 6'd2;
                  5: rdx = 6'd8;
                  6: rdx = 6'd16;
                  7: rdx = itp_pkg::RADIX_MAX;
                  8, 9: rdx = 6'($urandom_range(2, 36));
                  10: rdx = 6'd1;
                  default: rdx = 6'($urandom_range(37, 63));
               endcase
               case ($urandom_range(0, 9))
                  0: bits = 7'd0;
                  1: bits = 7'd1;
                  2: bits = 7'd64;
                  3: bits = 7'd63;
                  4: bits = 7'd32;
                  5: bits = 7'd8;
                  6, 7: bits = 7'($urandom_range(1, 64));
                  8: bits = 7'd16;
                  default: bits = 7'($urandom_range(65, 127));
               endcase
               sgn = 1'($urandom);
            end
         endcase
         set_config(rdx, bits, sgn);
         if (ph < 4) begin
            sender_idle = 30;
            receiver_idle = 51;
         end else if (ph < 8) begin
            sender_idle = 51;
            receiver_idle = 30;
         end else begin
            sender_idle = 0;
            receiver_idle = 0;
         end
         phase_start = words_sent;
         split_done = (ph % 2 == 0);
         while (words_sent - phase_start < WORDS_PER_PHASE) begin
            txt = make_text();
            push_text(txt, 1'($urandom), 1'b1, !split_done && txt.size() >= 2);
            if (txt.size() >= 2) split_done = 1'b1;
         end
      end

      drain();
      repeat (4 * SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_numbers.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
